### rtl/hkm_pkg.sv
package hkm_pkg;

  // table and device sizing
  localparam int TABLE_ENTRIES = 16;
  localparam int DEVICE_COUNT  = 8;
  localparam int RESULT_LIMIT  = 16;
  localparam int SCAN_MAX      = (TABLE_ENTRIES < RESULT_LIMIT) ? TABLE_ENTRIES : RESULT_LIMIT;
  localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DEV_AW        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int SCAN_AW       = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
  localparam int CNT_W         = $clog2(SCAN_MAX + 1);

  // field widths
  localparam int CODE_W  = 11;
  localparam int KEY_W   = 10;
  localparam int MODE_W  = 4;
  localparam int DEVF_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int DUR_W   = 16;
  localparam int ACT_W   = 5;
  localparam int KVAL_W  = 2;
  localparam int MOD_W   = 4;
  localparam int GMOD_W  = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // request codes
  localparam logic            ACT_LOAD     = 1'b0;
  localparam logic            ACT_EVENT    = 1'b1;
  localparam logic [KVAL_W-1:0] KVAL_RELEASE = 2'd0;
  localparam logic [KVAL_W-1:0] KVAL_PRESS   = 2'd1;

  // modifier key codes
  localparam logic [CODE_W-1:0] CODE_LCTRL = 11'd29;
  localparam logic [CODE_W-1:0] CODE_LALT  = 11'd56;
  localparam logic [CODE_W-1:0] CODE_RCTRL = 11'd97;
  localparam logic [CODE_W-1:0] CODE_RALT  = 11'd100;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_HOLD   = 2'd1,
    REG_LONG   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    OUT_FIRE   = 2'd0,
    OUT_ARMED  = 2'd1,
    OUT_CANCEL = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [MODE_W-1:0] mode;
    logic              armed;
    logic [DEVF_W-1:0] dev;
  } entry_t;

  typedef struct packed {
    logic [ACT_W-1:0] active;
    logic [DUR_W-1:0] hold;
    logic [DUR_W-1:0] long_hold;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              set;
    logic [DEV_AW-1:0] dev;
    logic [MOD_W-1:0]  bits;
  } mod_upd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    outcome_e          outcome;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } result_t;

  // per-device modifier bit for a code: lctrl, lalt, rctrl, ralt
  function automatic logic [MOD_W-1:0] mod_bit(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] b;
    case (code)
      CODE_LCTRL: b = 4'b0001;
      CODE_LALT:  b = 4'b0010;
      CODE_RCTRL: b = 4'b0100;
      CODE_RALT:  b = 4'b1000;
      default:    b = 4'b0000;
    endcase
    return b;
  endfunction

endpackage

### rtl/hkm_if.sv
interface hkm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [hkm_pkg::DEVF_W-1:0]    device_index;
  logic                          event_kind;
  logic [hkm_pkg::KEY_W-1:0]     key_code;
  logic [hkm_pkg::KVAL_W-1:0]    key_value;
  logic [hkm_pkg::SLOT_W-1:0]    entry_index;
  logic [hkm_pkg::CODE_W-1:0]    entry_code;
  logic [hkm_pkg::MODE_W-1:0]    entry_mode;

  modport source (
    output valid, action, device_index, event_kind, key_code, key_value,
           entry_index, entry_code, entry_mode,
    input  ready
  );
  modport sink (
    input  valid, action, device_index, event_kind, key_code, key_value,
           entry_index, entry_code, entry_mode,
    output ready
  );
endinterface

interface hkm_res_if;
  logic                         valid;
  logic                         ready;
  logic [hkm_pkg::SLOT_W-1:0]   entry_hit;
  logic [1:0]                   outcome;
  logic [hkm_pkg::DUR_W-1:0]    hold_duration;
  logic                         last_of_run;

  modport source (
    output valid, entry_hit, outcome, hold_duration, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, entry_hit, outcome, hold_duration, last_of_run,
    output ready
  );
endinterface

### rtl/hkm_ram.sv
module hkm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/hkm_cfg.sv
module hkm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hkm_pkg::PADDR_W-1:0]   paddr,
  input  logic [hkm_pkg::PDATA_W-1:0]   pwdata,
  output logic [hkm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output hkm_pkg::cfg_t                 cfg_o
);

  hkm_pkg::cfg_t  cfg_q, cfg_d;
  hkm_pkg::reg_e  reg_sel;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_sel = hkm_pkg::reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        hkm_pkg::REG_ACTIVE: cfg_d.active    = pwdata[hkm_pkg::ACT_W-1:0];
        hkm_pkg::REG_HOLD:   cfg_d.hold      = pwdata[hkm_pkg::DUR_W-1:0];
        hkm_pkg::REG_LONG:   cfg_d.long_hold = pwdata[hkm_pkg::DUR_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hkm_pkg::REG_ACTIVE: prdata = hkm_pkg::PDATA_W'(cfg_q.active);
      hkm_pkg::REG_HOLD:   prdata = hkm_pkg::PDATA_W'(cfg_q.hold);
      hkm_pkg::REG_LONG:   prdata = hkm_pkg::PDATA_W'(cfg_q.long_hold);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/hkm_mods.sv
module hkm_mods (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hkm_pkg::mod_upd_t           upd_i,
  output logic [hkm_pkg::GMOD_W-1:0]  global_o
);

  logic [hkm_pkg::MOD_W-1:0] mods_q [hkm_pkg::DEVICE_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < hkm_pkg::DEVICE_COUNT; d++) begin
        mods_q[d] <= '0;
      end
    end else if (upd_i.en) begin
      if (upd_i.set) begin
        mods_q[upd_i.dev] <= mods_q[upd_i.dev] | upd_i.bits;
      end else begin
        mods_q[upd_i.dev] <= mods_q[upd_i.dev] & ~upd_i.bits;
      end
    end
  end

  // global ctrl/alt: left keys of every device
  always_comb begin
    global_o = '0;
    for (int d = 0; d < hkm_pkg::DEVICE_COUNT; d++) begin
      global_o = global_o | mods_q[d][hkm_pkg::GMOD_W-1:0];
    end
  end

endmodule

### rtl/hkm_engine.sv
module hkm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hkm_req_if.sink                     req,
  hkm_res_if.source                   res,
  input  hkm_pkg::cfg_t               cfg_i,
  input  logic [hkm_pkg::GMOD_W-1:0]  global_i,
  output hkm_pkg::mod_upd_t           mod_upd_o
);

  localparam int TBL_AW  = hkm_pkg::TBL_AW;
  localparam int SCAN_AW = hkm_pkg::SCAN_AW;
  localparam int CNT_W   = hkm_pkg::CNT_W;

  hkm_pkg::state_e                state_q, state_d;
  logic [SCAN_AW-1:0]             idx_q, idx_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [hkm_pkg::CODE_W-1:0]     code_q, code_d;
  logic [hkm_pkg::DEVF_W-1:0]     dev_q, dev_d;
  logic                           press_q, press_d;
  logic [hkm_pkg::GMOD_W-1:0]     gm_q, gm_d;
  logic                           pend_v_q, pend_v_d;
  hkm_pkg::result_t               pend_q, pend_d;
  logic                           out_v_q, out_v_d;
  hkm_pkg::result_t               out_q, out_d;
  logic [hkm_pkg::TABLE_ENTRIES-1:0] hv_q, hv_d;

  logic                           we;
  logic [TBL_AW-1:0]              waddr;
  hkm_pkg::entry_t                wdata;
  logic [TBL_AW-1:0]              raddr;
  logic [$bits(hkm_pkg::entry_t)-1:0] rdata_raw;
  hkm_pkg::entry_t                rdata;

  logic                           accept;
  logic                           out_free;
  logic                           armed;
  logic                           code_eq;
  logic                           hit;
  logic                           last_idx;
  logic                           adv;
  logic                           ev_ok;
  logic [CNT_W-1:0]               scan_n;
  hkm_pkg::result_t               new_res;
  logic [hkm_pkg::MOD_W-1:0]      mbits;

  hkm_ram #(
    .Width ($bits(hkm_pkg::entry_t)),
    .Depth (hkm_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata    = hkm_pkg::entry_t'(rdata_raw);
  assign accept   = req.valid & req.ready;
  assign out_free = !out_v_q || res.ready;

  // the armed flag reads as zero until the slot is loaded
  assign armed   = hv_q[TBL_AW'(idx_q)] & rdata.armed;
  assign code_eq = (rdata.code == code_q);
  assign hit     = press_q ? (code_eq && (rdata.mode[1:0] == gm_q))
                           : (armed && code_eq && (rdata.dev == dev_q));
  assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign adv      = !(hit && pend_v_q) || out_free;

  assign ev_ok = (req.action == hkm_pkg::ACT_EVENT)
              && (32'(req.device_index) < hkm_pkg::DEVICE_COUNT)
              && ((req.key_value == hkm_pkg::KVAL_PRESS)
                  || (req.key_value == hkm_pkg::KVAL_RELEASE));

  assign scan_n = (32'(cfg_i.active) > hkm_pkg::SCAN_MAX) ? CNT_W'(hkm_pkg::SCAN_MAX)
                                                          : CNT_W'(cfg_i.active);
  assign mbits  = hkm_pkg::mod_bit(code_q);

  always_comb begin
    new_res.slot = hkm_pkg::SLOT_W'(idx_q);
    new_res.last = 1'b0;
    new_res.dur  = '0;
    if (!press_q) begin
      new_res.outcome = hkm_pkg::OUT_CANCEL;
    end else if (rdata.mode[2]) begin
      new_res.outcome = hkm_pkg::OUT_ARMED;
      new_res.dur     = rdata.mode[3] ? cfg_i.long_hold : cfg_i.hold;
    end else begin
      new_res.outcome = hkm_pkg::OUT_FIRE;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    dev_d     = dev_q;
    press_d   = press_q;
    gm_d      = gm_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    out_v_d   = out_v_q && !res.ready;
    out_d     = out_q;
    hv_d      = hv_q;
    we        = 1'b0;
    waddr     = TBL_AW'(idx_q);
    wdata     = rdata;
    mod_upd_o = '0;
    req.ready = (state_q == hkm_pkg::ST_IDLE);

    case (state_q)
      hkm_pkg::ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (req.action == hkm_pkg::ACT_LOAD) begin
            if (32'(req.entry_index) < hkm_pkg::TABLE_ENTRIES) begin
              we          = 1'b1;
              waddr       = TBL_AW'(req.entry_index);
              wdata.code  = req.entry_code;
              wdata.mode  = req.entry_mode;
              wdata.armed = 1'b0;
              wdata.dev   = '0;
              hv_d[TBL_AW'(req.entry_index)] = 1'b1;
            end
          end else if (ev_ok) begin
            code_d  = {req.event_kind, req.key_code};
            dev_d   = req.device_index;
            press_d = (req.key_value == hkm_pkg::KVAL_PRESS);
            gm_d    = global_i;
            cnt_d   = scan_n;
            state_d = (scan_n == '0) ? hkm_pkg::ST_FLUSH : hkm_pkg::ST_SCAN;
          end
        end
      end
      hkm_pkg::ST_SCAN: begin
        if (adv) begin
          if (hit) begin
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = new_res;
            if (!press_q || rdata.mode[2]) begin
              we          = 1'b1;
              wdata.armed = press_q;
              wdata.dev   = press_q ? dev_q : '0;
            end
          end
          if (last_idx) begin
            state_d = hkm_pkg::ST_FLUSH;
          end else begin
            idx_d = idx_q + SCAN_AW'(1);
          end
        end
      end
      hkm_pkg::ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_v_d   = 1'b0;
          end
          mod_upd_o.en   = (mbits != '0);
          mod_upd_o.set  = press_q;
          mod_upd_o.dev  = hkm_pkg::DEV_AW'(dev_q);
          mod_upd_o.bits = mbits;
          state_d        = hkm_pkg::ST_IDLE;
        end
      end
      default: state_d = hkm_pkg::ST_IDLE;
    endcase

    // a stalled slot is read again so its data stays in front of the compare
    raddr = TBL_AW'(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hkm_pkg::ST_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      hv_q     <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      hv_q     <= hv_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    code_q  <= code_d;
    dev_q   <= dev_d;
    press_q <= press_d;
    gm_q    <= gm_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign res.valid         = out_v_q;
  assign res.entry_hit     = out_q.slot;
  assign res.outcome       = out_q.outcome;
  assign res.hold_duration = out_q.dur;
  assign res.last_of_run   = out_q.last;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hkm_pkg::ST_SCAN |-> CNT_W'(idx_q) < cnt_q)
    else $error("scan index past active entries");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hkm_pkg::ST_IDLE |-> !pend_v_q)
    else $error("pending result left behind after an event");

  a_mod_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_upd_o.en |-> state_q == hkm_pkg::ST_FLUSH)
    else $error("modifier update outside end of event");

  a_flush_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hkm_pkg::ST_FLUSH && !pend_v_q |=> state_q == hkm_pkg::ST_IDLE)
    else $error("event did not finish");

endmodule

### rtl/hotkey_matcher_top.sv
// Hotkey matcher. A request either loads one table slot (action 0, no result)
// or carries a key or switch event (action 1). A press scans slots 0 to n-1, with
// n = min(active_entries, 16), and returns one result per slot whose code equals the event
// code and whose ctrl/alt mode bits equal the global modifiers as they stood before the
// press: fire now, or hold armed with hold_ticks or long_hold_ticks. A release returns one
// cancel per armed slot with the same code and device. Results come in slot order, the last
// one flagged by last_of_run; repeats, unknown values and out-of-range devices return
// nothing. Table slots live in a single-port-read, single-port-write memory that is read,
// checked and written back one slot per cycle while results are not stalled: an event is
// accepted, its n slots are scanned, the final result is handed over and the per-device
// ctrl/alt state updated, then the next request is taken. A slot must be loaded before a
// press can look at it. Configuration goes over the APB port at byte addresses 0, 4 and 8;
// the user must write it only while no event is in flight; the block does not enforce it.
module hotkey_matcher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hkm_req_if.sink                       req_i,
  hkm_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hkm_pkg::PADDR_W-1:0]   paddr,
  input  logic [hkm_pkg::PDATA_W-1:0]   pwdata,
  output logic [hkm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  hkm_pkg::cfg_t                cfg;
  hkm_pkg::mod_upd_t            mod_upd;
  logic [hkm_pkg::GMOD_W-1:0]   global_mods;

  // configuration registers: active entries, short and long hold lengths
  hkm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // per-device modifier bits, updated at the end of each modifier key event
  hkm_mods u_mods (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (mod_upd),
    .global_o (global_mods)
  );

  // table memory, slot scan and result register
  hkm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .res       (res_o),
    .cfg_i     (cfg),
    .global_i  (global_mods),
    .mod_upd_o (mod_upd)
  );

endmodule
